### design/hqsr_pkg.sv
// Package for the handle queue with search and removal.
// Holds the sizing constants, command and status codes, the request and result
// transaction structs and the controller state type. No dependencies.
package hqsr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_BITS = 32;

    localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int HANDLE_W = 32;
    localparam int ID_W     = 16;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    localparam logic [HANDLE_W-1:0] HANDLE_MASK = (HANDLE_BITS >= HANDLE_W) ?
        {HANDLE_W{1'b1}} : HANDLE_W'((64'd1 << HANDLE_BITS) - 64'd1);

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [HANDLE_W-1:0] item_handle;
        logic [ID_W-1:0]     item_id;
        logic [POS_W-1:0]    position;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] found_handle;
        logic [ID_W-1:0]     found_id;
        logic [LEN_W-1:0]    queue_length;
    } result_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     id;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_SHIFT
    } state_t;

endpackage

### design/hqsr_ram.sv
// Simple dual-port entry memory: one write port, one read port with
// registered read data (old data on a same-address collision).
// Depends on nothing; sized by its parameters.
module hqsr_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/handle_queue_search_remove_core.sv
// Handle queue with search and removal: top level and controller.
// Append, and any command that fails up front, completes without reading the
// entry memory; pop and read position fetch one entry; find compares entries
// from the head and stops at the first hit or the end of the queue; remove also
// moves each entry after the hit down one position. The walk reads one entry per
// cycle from the single read port of the entry memory, so one transaction runs
// at a time (busy, for commands that read the memory, is high until their result
// strobe). The result strobe cannot be stalled. Reset empties the queue; entry
// contents are not cleared. Depends on hqsr_pkg and hqsr_ram.
module handle_queue_search_remove_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  hqsr_pkg::request_t request,
    output logic               done,
    output hqsr_pkg::result_t  result
);

    localparam int SUM_W = hqsr_pkg::SLOT_W + 1;

    hqsr_pkg::state_t                  state_reg, state_next;
    logic [hqsr_pkg::SLOT_W-1:0]       head_reg, head_next;
    logic [hqsr_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [hqsr_pkg::COUNT_W-1:0]      idx_reg, idx_next;
    logic                              done_reg, done_next;

    logic [hqsr_pkg::CMD_W-1:0]        cmd_reg, cmd_next;
    logic [hqsr_pkg::HANDLE_W-1:0]     key_handle_reg, key_handle_next;
    logic [hqsr_pkg::ID_W-1:0]         key_id_reg, key_id_next;
    logic [hqsr_pkg::ID_W-1:0]         hit_id_reg, hit_id_next;
    hqsr_pkg::result_t                 result_reg, result_next;

    logic                              wr_en;
    logic [hqsr_pkg::SLOT_W-1:0]       wr_addr;
    hqsr_pkg::entry_t                  wr_data;
    logic                              rd_en;
    logic [hqsr_pkg::SLOT_W-1:0]       rd_addr;
    hqsr_pkg::entry_t                  rd_data;

    logic                              accept;
    logic                              hit;
    logic                              more;
    logic [hqsr_pkg::HANDLE_W-1:0]     in_handle;
    logic                              pos_in_range;

    function automatic logic [hqsr_pkg::SLOT_W-1:0] slot_of(
        input logic [hqsr_pkg::SLOT_W-1:0]  base,
        input logic [hqsr_pkg::COUNT_W-1:0] pos
    );
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + SUM_W'(pos);
        if (sum >= SUM_W'(hqsr_pkg::QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(hqsr_pkg::QUEUE_DEPTH);
        end
        return sum[hqsr_pkg::SLOT_W-1:0];
    endfunction

    hqsr_ram #(
        .DEPTH (hqsr_pkg::QUEUE_DEPTH),
        .WIDTH ($bits(hqsr_pkg::entry_t))
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy   = (state_reg != hqsr_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign in_handle    = request.item_handle & hqsr_pkg::HANDLE_MASK;
    assign pos_in_range = int'(request.position) < int'(count_reg);

    // During the walk, rd_data holds the entry at position idx_reg - 1.
    assign hit  = (cmd_reg == hqsr_pkg::CMD_FIND) ? (rd_data.id == key_id_reg)
                                                  : (rd_data.handle == key_handle_reg);
    assign more = idx_reg < count_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hqsr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.command) inside
                        hqsr_pkg::CMD_POP:
                            state_next = (count_reg != '0) ? hqsr_pkg::ST_FETCH
                                                           : hqsr_pkg::ST_IDLE;
                        hqsr_pkg::CMD_READ:
                            state_next = pos_in_range ? hqsr_pkg::ST_FETCH
                                                      : hqsr_pkg::ST_IDLE;
                        hqsr_pkg::CMD_FIND, hqsr_pkg::CMD_REMOVE:
                            state_next = (count_reg != '0) ? hqsr_pkg::ST_SCAN
                                                           : hqsr_pkg::ST_IDLE;
                        default:
                            state_next = hqsr_pkg::ST_IDLE;
                    endcase
                end
            end
            hqsr_pkg::ST_FETCH:
                state_next = hqsr_pkg::ST_IDLE;
            hqsr_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = (cmd_reg == hqsr_pkg::CMD_REMOVE && more)
                               ? hqsr_pkg::ST_SHIFT : hqsr_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = more ? hqsr_pkg::ST_SCAN : hqsr_pkg::ST_IDLE;
                end
            end
            hqsr_pkg::ST_SHIFT:
                state_next = more ? hqsr_pkg::ST_SHIFT : hqsr_pkg::ST_IDLE;
            default:
                state_next = hqsr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        done_next       = 1'b0;
        cmd_next        = cmd_reg;
        key_handle_next = key_handle_reg;
        key_id_next     = key_id_reg;
        hit_id_next     = hit_id_reg;
        result_next     = result_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_of(head_reg, idx_reg - hqsr_pkg::COUNT_W'(2));
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = slot_of(head_reg, idx_reg);

        unique case (state_reg)
            hqsr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = request.command;
                    key_handle_next = in_handle;
                    key_id_next     = request.item_id;
                    idx_next        = hqsr_pkg::COUNT_W'(1);
                    result_next     = '{status: hqsr_pkg::STATUS_EMPTY, found_handle: '0,
                                        found_id: '0,
                                        queue_length: hqsr_pkg::LEN_W'(count_reg)};
                    case (request.command) inside
                        hqsr_pkg::CMD_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg == hqsr_pkg::COUNT_W'(hqsr_pkg::QUEUE_DEPTH))
                            begin
                                result_next.status = hqsr_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_addr      = slot_of(head_reg, count_reg);
                                wr_data      = '{handle: in_handle, id: request.item_id};
                                count_next   = count_reg + hqsr_pkg::COUNT_W'(1);
                                result_next  = '{status: hqsr_pkg::STATUS_OK,
                                                 found_handle: in_handle,
                                                 found_id: request.item_id,
                                                 queue_length: hqsr_pkg::LEN_W'(count_next)};
                            end
                        end
                        hqsr_pkg::CMD_POP, hqsr_pkg::CMD_FIND, hqsr_pkg::CMD_REMOVE:
                        begin
                            rd_addr = head_reg;
                            if (count_reg != '0)
                            begin
                                rd_en = 1'b1;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        hqsr_pkg::CMD_READ:
                        begin
                            rd_addr = slot_of(head_reg,
                                              hqsr_pkg::COUNT_W'(request.position));
                            if (pos_in_range)
                            begin
                                rd_en = 1'b1;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            hqsr_pkg::ST_FETCH:
            begin
                done_next = 1'b1;
                if (cmd_reg == hqsr_pkg::CMD_POP)
                begin
                    head_next  = slot_of(head_reg, hqsr_pkg::COUNT_W'(1));
                    count_next = count_reg - hqsr_pkg::COUNT_W'(1);
                end
                result_next = '{status: hqsr_pkg::STATUS_OK, found_handle: rd_data.handle,
                                found_id: rd_data.id,
                                queue_length: hqsr_pkg::LEN_W'(count_next)};
            end
            hqsr_pkg::ST_SCAN:
            begin
                // Keep one read in flight so each cycle compares one entry.
                if (more)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + hqsr_pkg::COUNT_W'(1);
                end
                if (hit)
                begin
                    hit_id_next = rd_data.id;
                    if (cmd_reg == hqsr_pkg::CMD_REMOVE && !more)
                    begin
                        count_next = count_reg - hqsr_pkg::COUNT_W'(1);
                    end
                    if (cmd_reg == hqsr_pkg::CMD_FIND || !more)
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: hqsr_pkg::STATUS_OK,
                                        found_handle: rd_data.handle,
                                        found_id: rd_data.id,
                                        queue_length: hqsr_pkg::LEN_W'(count_next)};
                    end
                end
                else if (!more)
                begin
                    done_next = 1'b1;
                end
            end
            hqsr_pkg::ST_SHIFT:
            begin
                // Move the entry read last cycle down by one position.
                wr_en = 1'b1;
                if (more)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + hqsr_pkg::COUNT_W'(1);
                end
                else
                begin
                    count_next  = count_reg - hqsr_pkg::COUNT_W'(1);
                    done_next   = 1'b1;
                    result_next = '{status: hqsr_pkg::STATUS_OK,
                                    found_handle: key_handle_reg,
                                    found_id: hit_id_reg,
                                    queue_length: hqsr_pkg::LEN_W'(count_next)};
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hqsr_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_handle_reg <= key_handle_next;
        key_id_reg     <= key_id_next;
        hit_id_reg     <= hit_id_next;
        result_reg     <= result_next;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for handle_queue_search_remove_core.
// Keeps its own copy of the handle queue to predict each result. Needs hqsr_pkg
// and the core RTL.
module testbench;

    localparam logic [hqsr_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [hqsr_pkg::CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [hqsr_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
    localparam int RANDOM_ITEMS = 400;
    localparam int POOL_SIZE    = 24;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } traffic_mix_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    hqsr_pkg::request_t request = '0;
    logic               busy;
    logic               done;
    hqsr_pkg::result_t  result;

    // Shadow copy of the queue, updated as each transaction is accepted.
    logic [hqsr_pkg::HANDLE_W-1:0] shadow_handle [hqsr_pkg::QUEUE_DEPTH];
    logic [hqsr_pkg::ID_W-1:0]     shadow_id [hqsr_pkg::QUEUE_DEPTH];
    int                            shadow_head = 0;
    int                            shadow_count = 0;

    hqsr_pkg::request_t            commands_to_send[$];
    hqsr_pkg::result_t             replies_due[$];
    logic [hqsr_pkg::HANDLE_W-1:0] handle_pool[$];
    logic [hqsr_pkg::ID_W-1:0]     id_pool[$];
    int                            total_items = 0;
    int                            sent_count = 0;
    int                            burst_left = 0;
    int                            gap_left = 0;
    int                            error_count = 0;

    handle_queue_search_remove_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic hqsr_pkg::result_t apply_command(hqsr_pkg::request_t req);
        hqsr_pkg::result_t             res;
        logic [hqsr_pkg::HANDLE_W-1:0] handle;
        int                            slot;
        int                            k;
        int                            j;
        begin
            res = '0;
            res.status = hqsr_pkg::STATUS_EMPTY;
            handle = req.item_handle & hqsr_pkg::HANDLE_MASK;
            case (req.command)
                hqsr_pkg::CMD_APPEND:
                begin
                    if (shadow_count >= hqsr_pkg::QUEUE_DEPTH)
                    begin
                        res.status = hqsr_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        slot = (shadow_head + shadow_count) % hqsr_pkg::QUEUE_DEPTH;
                        shadow_handle[slot] = handle;
                        shadow_id[slot] = req.item_id;
                        shadow_count++;
                        res.status = hqsr_pkg::STATUS_OK;
                        res.found_handle = handle;
                        res.found_id = req.item_id;
                    end
                end
                hqsr_pkg::CMD_POP:
                begin
                    if (shadow_count != 0)
                    begin
                        res.status = hqsr_pkg::STATUS_OK;
                        res.found_handle = shadow_handle[shadow_head];
                        res.found_id = shadow_id[shadow_head];
                        shadow_head = (shadow_head + 1) % hqsr_pkg::QUEUE_DEPTH;
                        shadow_count--;
                    end
                end
                hqsr_pkg::CMD_REMOVE:
                begin
                    for (k = 0; k < shadow_count; k++)
                    begin
                        slot = (shadow_head + k) % hqsr_pkg::QUEUE_DEPTH;
                        if (res.status != hqsr_pkg::STATUS_OK &&
                            shadow_handle[slot] == handle)
                        begin
                            res.status = hqsr_pkg::STATUS_OK;
                            res.found_handle = handle;
                            res.found_id = shadow_id[slot];
                            // Later entries move up one place to keep the order.
                            for (j = k; j + 1 < shadow_count; j++)
                            begin
                                shadow_handle[(shadow_head + j) % hqsr_pkg::QUEUE_DEPTH] =
                                    shadow_handle[(shadow_head + j + 1) % hqsr_pkg::QUEUE_DEPTH];
                                shadow_id[(shadow_head + j) % hqsr_pkg::QUEUE_DEPTH] =
                                    shadow_id[(shadow_head + j + 1) % hqsr_pkg::QUEUE_DEPTH];
                            end
                        end
                    end
                    if (res.status == hqsr_pkg::STATUS_OK)
                        shadow_count--;
                end
                hqsr_pkg::CMD_FIND:
                begin
                    for (k = 0; k < shadow_count; k++)
                    begin
                        slot = (shadow_head + k) % hqsr_pkg::QUEUE_DEPTH;
                        if (res.status != hqsr_pkg::STATUS_OK &&
                            shadow_id[slot] == req.item_id)
                        begin
                            res.status = hqsr_pkg::STATUS_OK;
                            res.found_handle = shadow_handle[slot];
                            res.found_id = shadow_id[slot];
                        end
                    end
                end
                hqsr_pkg::CMD_READ:
                begin
                    if (int'(req.position) < shadow_count)
                    begin
                        slot = (shadow_head + int'(req.position)) % hqsr_pkg::QUEUE_DEPTH;
                        res.status = hqsr_pkg::STATUS_OK;
                        res.found_handle = shadow_handle[slot];
                        res.found_id = shadow_id[slot];
                    end
                end
                default:
                begin
                    res.status = hqsr_pkg::STATUS_EMPTY;
                end
            endcase
            res.queue_length = hqsr_pkg::LEN_W'(shadow_count);
            return res;
        end
    endfunction

    function automatic hqsr_pkg::request_t make_request(
        logic [hqsr_pkg::CMD_W-1:0]    cmd,
        logic [hqsr_pkg::HANDLE_W-1:0] handle,
        logic [hqsr_pkg::ID_W-1:0]     id,
        logic [hqsr_pkg::POS_W-1:0]    pos);
        hqsr_pkg::request_t req;
        begin
            req.command = cmd;
            req.item_handle = handle;
            req.item_id = id;
            req.position = pos;
            return req;
        end
    endfunction

    // Small value sets make duplicate handles and ids common.
    function automatic logic [hqsr_pkg::HANDLE_W-1:0] pick_handle();
        begin
            case ($urandom_range(0, 9))
                0:       return '0;
                1:       return '1;
                2, 3, 4: return hqsr_pkg::HANDLE_W'($urandom_range(0, 7));
                default: return $urandom;
            endcase
        end
    endfunction

    function automatic logic [hqsr_pkg::ID_W-1:0] pick_id();
        begin
            case ($urandom_range(0, 9))
                0:          return '0;
                1:          return '1;
                2, 3, 4, 5: return hqsr_pkg::ID_W'($urandom_range(0, 7));
                default:    return hqsr_pkg::ID_W'($urandom_range(0, 16'hFFFF));
            endcase
        end
    endfunction

    function automatic logic [hqsr_pkg::CMD_W-1:0] pick_command(traffic_mix_t mix);
        int roll;
        int cut_append;
        int cut_pop;
        int cut_remove;
        int cut_find;
        begin
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:
                begin
                    cut_append = 60; cut_pop = 68; cut_remove = 78; cut_find = 87;
                end
                MIX_DRAIN:
                begin
                    cut_append = 15; cut_pop = 55; cut_remove = 75; cut_find = 85;
                end
                default:
                begin
                    cut_append = 30; cut_pop = 45; cut_remove = 65; cut_find = 80;
                end
            endcase
            if (roll < cut_append)
                return hqsr_pkg::CMD_APPEND;
            else if (roll < cut_pop)
                return hqsr_pkg::CMD_POP;
            else if (roll < cut_remove)
                return hqsr_pkg::CMD_REMOVE;
            else if (roll < cut_find)
                return hqsr_pkg::CMD_FIND;
            else if (roll < 97)
                return hqsr_pkg::CMD_READ;
            else
                return CMD_SPARE_FIRST + hqsr_pkg::CMD_W'($urandom_range(0, 2));
        end
    endfunction

    task automatic report_field(string name, logic [hqsr_pkg::HANDLE_W-1:0] want,
                                logic [hqsr_pkg::HANDLE_W-1:0] got);
        begin
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                error_count++;
            end
        end
    endtask

    // Driver: sends commands in bursts with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                replies_due.push_back(apply_command(request));
                sent_count <= sent_count + 1;
            end
            if (!(start && busy))
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (commands_to_send.size() != 0)
                begin
                    request <= commands_to_send.pop_front();
                    start <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %p", $time, result);
                error_count++;
            end
            else
            begin
                hqsr_pkg::result_t want;
                want = replies_due.pop_front();
                report_field("status", hqsr_pkg::HANDLE_W'(want.status),
                             hqsr_pkg::HANDLE_W'(result.status));
                report_field("found_handle", want.found_handle, result.found_handle);
                report_field("found_id", hqsr_pkg::HANDLE_W'(want.found_id),
                             hqsr_pkg::HANDLE_W'(result.found_id));
                report_field("queue_length", hqsr_pkg::HANDLE_W'(want.queue_length),
                             hqsr_pkg::HANDLE_W'(result.queue_length));
            end
        end
    end

    initial
    begin
        traffic_mix_t                  mix;
        logic [hqsr_pkg::CMD_W-1:0]    cmd;
        logic [hqsr_pkg::HANDLE_W-1:0] handle;
        logic [hqsr_pkg::ID_W-1:0]     id;
        logic [hqsr_pkg::POS_W-1:0]    pos;
        int                            phase_left;
        int                            n;

        // Directed opening: empty-queue failures, spare codes, extremes,
        // duplicates, a mid-queue remove and reads around the end.
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_POP, '1, '1, '1));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_REMOVE, '0, '0, '0));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_FIND, '0, '0, '0));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_READ, '0, '0, '1));
        commands_to_send.push_back(make_request(CMD_SPARE_FIRST, '1, '1, '1));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_APPEND, '0, '0, '0));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_APPEND, '1, '1, '1));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_APPEND, 32'hA5A5_5A5A,
                                                16'h1234, '0));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_APPEND, '1, 16'h0007, '0));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_FIND, '0, '1, '0));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_FIND, '0, 16'h4321, '0));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_READ, '0, '0, 4'd0));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_READ, '0, '0, 4'd3));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_READ, '0, '0, 4'd4));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_REMOVE, '1, '0, '0));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_READ, '0, '0, 4'd1));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_REMOVE, 32'h0000_1111,
                                                '0, '0));
        commands_to_send.push_back(make_request(hqsr_pkg::CMD_POP, '0, '0, '0));
        commands_to_send.push_back(make_request(CMD_SPARE_MID, '0, '0, '0));
        commands_to_send.push_back(make_request(CMD_SPARE_LAST, '1, '1, '1));

        // Random part in phases that lean toward filling, draining or neither,
        // so the queue runs full and empty repeatedly.
        phase_left = 0;
        mix = MIX_FILL;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(20, 60);
                mix = traffic_mix_t'($urandom_range(0, 2));
            end
            phase_left--;
            cmd = pick_command(mix);
            handle = pick_handle();
            id = pick_id();
            pos = ($urandom_range(0, 9) < 7) ? hqsr_pkg::POS_W'($urandom_range(0, 7))
                                              : hqsr_pkg::POS_W'($urandom);
            if (cmd == hqsr_pkg::CMD_APPEND)
            begin
                handle_pool.push_back(handle);
                id_pool.push_back(id);
                if (handle_pool.size() > POOL_SIZE)
                begin
                    void'(handle_pool.pop_front());
                    void'(id_pool.pop_front());
                end
            end
            else if (handle_pool.size() != 0 && $urandom_range(0, 9) < 6)
            begin
                // Aim removes and finds at entries that were likely appended.
                handle = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
                id = id_pool[$urandom_range(0, id_pool.size() - 1)];
            end
            commands_to_send.push_back(make_request(cmd, handle, id, pos));
        end
        total_items = commands_to_send.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count < total_items || replies_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
design/hqsr_pkg.sv
design/hqsr_ram.sv
design/handle_queue_search_remove_core.sv
test/testbench.sv
